// ===== rtl/core/snhr_pkg.sv =====
`timescale 1ns / 1ps

package snhr_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int SP_W = 6;
  localparam int POS_W = 24;
  localparam int WORD_W = 32;
  localparam int CNT_W = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 24;
  localparam logic [WORD_W-1:0] DEPTH_FAR = '1;
  localparam logic [CNT_W-1:0] HEADER_WORDS = 7'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SELECT_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE = 1'd1;

  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_POP   = 3'd1,
    OP_PUSH  = 3'd2,
    OP_LOAD  = 3'd3,
    OP_DEPTH = 3'd4,
    OP_FLUSH = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_UNDERFLOW = 2'd1,
    ERR_OVERFLOW  = 2'd2,
    ERR_INVALID   = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PLAN,
    ST_WORDS,
    ST_STATUS
  } state_t;

  typedef struct packed {
    logic load;
    logic plan;
    logic emit_word;
    logic emit_status;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic no_words;
    logic last_word;
  } dp_status_t;

endpackage

// ===== rtl/core/selection_name_stack_hit_recorder.sv =====
`timescale 1ns / 1ps

// Selection-mode hit recorder with a name stack of STACK_DEPTH entries.
// Configuration: cfg_write with cfg_index 0 sets select_mode, index 1 buffer_size;
// writes take effect at once; the user makes them only while idle, not enforced.
// Commands: an operation word is taken when start is high and busy is low.
// Each command yields one or more result words, each shown for one cycle with
// out_valid high; the final word of a command carries last.
// A command that writes no buffer word yields one status word after its plan
// state. A command that flushes a hit record is planned, then emits one buffer
// word per cycle, n words in all (n up to STACK_DEPTH + 3), set by the single
// read port of the name memory.
// busy falls in the cycle the last word is shown, so the next command may start
// there. State changes are applied when the last word goes out.
// Reset clears the stack pointer, depths, hit flag, write position, overflow
// flag, hit count and both configuration registers; the name memory is not
// cleared. The receiver cannot stall, so words go out at the pace above.
module selection_name_stack_hit_recorder #(
  parameter int STACK_DEPTH = snhr_pkg::STACK_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [snhr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [snhr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           start,
  output logic                           busy,
  input  logic [2:0]                     operation,
  input  logic [snhr_pkg::WORD_W-1:0]     name_value,
  input  logic [snhr_pkg::WORD_W-1:0]     depth_value,
  output logic                           out_valid,
  output logic                           has_word,
  output logic [snhr_pkg::POS_W-1:0]      word_index,
  output logic [snhr_pkg::WORD_W-1:0]     word_value,
  output logic [1:0]                     error_code,
  output logic                           overflow_flag,
  output logic [snhr_pkg::SP_W-1:0]       stack_depth,
  output logic [snhr_pkg::POS_W-1:0]      hit_count,
  output logic                           last
);
  import snhr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  snhr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  snhr_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .operation     (operation),
    .name_value    (name_value),
    .depth_value   (depth_value),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .has_word      (has_word),
    .word_index    (word_index),
    .word_value    (word_value),
    .error_code    (error_code),
    .overflow_flag (overflow_flag),
    .stack_depth   (stack_depth),
    .hit_count     (hit_count),
    .last          (last)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |=> !out_valid)
    else $error("result word followed the last word of a command");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_word |-> last)
    else $error("status word not marked last");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (int'(stack_depth) <= STACK_DEPTH))
    else $error("stack depth beyond capacity");

endmodule

// ===== rtl/core/snhr_ctrl.sv =====
`timescale 1ns / 1ps

module snhr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  snhr_pkg::dp_status_t stat,
  output snhr_pkg::ctrl_cmd_t cmd,
  output logic                busy
);
  import snhr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_PLAN;
        end
      end
      ST_PLAN: begin
        state_next = stat.no_words ? ST_STATUS : ST_WORDS;
      end
      ST_WORDS: begin
        if (stat.last_word) begin
          state_next = ST_IDLE;
        end
      end
      ST_STATUS: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      ST_PLAN: begin
        cmd.plan = 1'b1;
      end
      ST_WORDS: begin
        cmd.emit_word = 1'b1;
        cmd.commit = stat.last_word;
      end
      ST_STATUS: begin
        cmd.emit_status = 1'b1;
        cmd.commit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/core/snhr_datapath.sv =====
`timescale 1ns / 1ps

module snhr_datapath #(
  parameter int STACK_DEPTH = snhr_pkg::STACK_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [snhr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [snhr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [2:0]                     operation,
  input  logic [snhr_pkg::WORD_W-1:0]     name_value,
  input  logic [snhr_pkg::WORD_W-1:0]     depth_value,
  input  snhr_pkg::ctrl_cmd_t            cmd,
  output snhr_pkg::dp_status_t           stat,
  output logic                           out_valid,
  output logic                           has_word,
  output logic [snhr_pkg::POS_W-1:0]      word_index,
  output logic [snhr_pkg::WORD_W-1:0]     word_value,
  output logic [1:0]                     error_code,
  output logic                           overflow_flag,
  output logic [snhr_pkg::SP_W-1:0]       stack_depth,
  output logic [snhr_pkg::POS_W-1:0]      hit_count,
  output logic                           last
);
  import snhr_pkg::*;

  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);

  logic [WORD_W-1:0] name_mem [STACK_DEPTH];
  logic [WORD_W-1:0] rd_data;

  logic              select_mode;
  logic [POS_W-1:0]  buffer_size;

  logic [SP_W-1:0]   sp;
  logic [WORD_W-1:0] min_depth;
  logic [WORD_W-1:0] max_depth;
  logic              hit_pending;
  logic [POS_W-1:0]  write_position;
  logic              overflowed;
  logic [POS_W-1:0]  records;

  logic [2:0]        op_r;
  logic [WORD_W-1:0] name_r;
  logic [WORD_W-1:0] depth_r;

  logic              act;
  logic              flush_r;
  err_t              err_r;
  logic [CNT_W-1:0]  n_emit;
  logic [SP_W-1:0]   sp_final;
  logic              ovf_final;
  logic [POS_W-1:0]  hits_final;
  logic [CNT_W-1:0]  k;

  logic              legal;
  logic              changes;
  err_t              err_c;
  logic [SP_W-1:0]   sp_c;
  logic              flush_c;
  logic [CNT_W-1:0]  total;
  logic [POS_W-1:0]  room;
  logic [CNT_W-1:0]  n_c;
  logic              ovf_c;
  logic [CNT_W-1:0]  rd_ptr;
  logic [SP_W-1:0]   sp_less;
  logic [WORD_W-1:0] word_sel;

  always_comb begin
    legal = 1'b1;
    changes = 1'b0;
    err_c = ERR_NONE;
    sp_c = sp;
    unique case (op_r)
      OP_INIT: begin
        changes = 1'b1;
        sp_c = '0;
      end
      OP_POP: begin
        if (sp == '0) begin
          legal = 1'b0;
          err_c = ERR_UNDERFLOW;
        end else begin
          changes = 1'b1;
          sp_c = sp - SP_W'(1);
        end
      end
      OP_PUSH: begin
        if (sp >= SP_FULL) begin
          legal = 1'b0;
          err_c = ERR_OVERFLOW;
        end else begin
          changes = 1'b1;
          sp_c = sp + SP_W'(1);
        end
      end
      OP_LOAD: begin
        if (sp == '0 || sp > SP_FULL) begin
          legal = 1'b0;
          err_c = ERR_INVALID;
        end else begin
          changes = 1'b1;
        end
      end
      OP_FLUSH: begin
        changes = 1'b1;
      end
      default: begin
        changes = 1'b0;
      end
    endcase
    if (!select_mode) begin
      legal = 1'b0;
      changes = 1'b0;
      err_c = ERR_NONE;
      sp_c = sp;
    end
  end

  assign flush_c = changes && hit_pending && (buffer_size != '0);
  assign total = CNT_W'(sp) + HEADER_WORDS;
  assign room = (write_position < buffer_size) ? (buffer_size - write_position) : '0;
  assign n_c = !flush_c ? '0 : ((room < POS_W'(total)) ? room[CNT_W-1:0] : total);
  assign ovf_c = overflowed ||
                 (flush_c && (({1'b0, write_position} + (POS_W + 1)'(total)) >
                              {1'b0, buffer_size}));

  assign rd_ptr = k - CNT_W'(2);
  assign sp_less = sp - SP_W'(1);

  assign stat.no_words = (n_c == '0);
  assign stat.last_word = (k == n_emit - CNT_W'(1));

  always_comb begin
    unique case (k)
      CNT_W'(0): word_sel = WORD_W'(sp);
      CNT_W'(1): word_sel = min_depth;
      CNT_W'(2): word_sel = max_depth;
      default:   word_sel = rd_data;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= name_mem[rd_ptr[IDX_W-1:0]];
    if (cmd.commit && act) begin
      if (op_r == OP_PUSH) begin
        name_mem[sp[IDX_W-1:0]] <= name_r;
      end else if (op_r == OP_LOAD) begin
        name_mem[sp_less[IDX_W-1:0]] <= name_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= operation;
      name_r <= name_value;
      depth_r <= depth_value;
    end
    if (cmd.plan) begin
      act <= legal;
      flush_r <= flush_c;
      err_r <= err_c;
      n_emit <= n_c;
      sp_final <= sp_c;
      ovf_final <= ovf_c;
      hits_final <= records + POS_W'(flush_c);
      k <= '0;
    end else if (cmd.emit_word) begin
      k <= k + CNT_W'(1);
    end
    if (cmd.emit_word) begin
      has_word <= 1'b1;
      word_index <= write_position + POS_W'(k);
      word_value <= word_sel;
      last <= stat.last_word;
    end else if (cmd.emit_status) begin
      has_word <= 1'b0;
      word_index <= '0;
      word_value <= '0;
      last <= 1'b1;
    end
    if (cmd.emit_word || cmd.emit_status) begin
      error_code <= err_r;
      overflow_flag <= ovf_final;
      stack_depth <= sp_final;
      hit_count <= hits_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      select_mode <= 1'b0;
      buffer_size <= '0;
      sp <= '0;
      min_depth <= DEPTH_FAR;
      max_depth <= '0;
      hit_pending <= 1'b0;
      write_position <= '0;
      overflowed <= 1'b0;
      records <= '0;
    end else begin
      out_valid <= cmd.emit_word || cmd.emit_status;
      if (cfg_write) begin
        if (cfg_index == CFG_SELECT_MODE) begin
          select_mode <= cfg_data[0];
        end else if (cfg_index == CFG_BUFFER_SIZE) begin
          buffer_size <= cfg_data[POS_W-1:0];
        end
      end
      if (cmd.commit) begin
        if (flush_r) begin
          records <= hits_final;
          min_depth <= DEPTH_FAR;
          max_depth <= '0;
          hit_pending <= 1'b0;
          write_position <= write_position + POS_W'(n_emit);
          overflowed <= ovf_final;
        end
        sp <= sp_final;
        if (act && op_r == OP_DEPTH) begin
          if (depth_r < min_depth) begin
            min_depth <= depth_r;
          end
          if (depth_r > max_depth) begin
            max_depth <= depth_r;
          end
          hit_pending <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== dv/tb_selection_name_stack_hit_recorder.sv =====
`timescale 1ns / 1ps

module tb_selection_name_stack_hit_recorder;
  import snhr_pkg::*;

  localparam int STACK_MAX = STACK_DEPTH_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [CFG_DATA_W-1:0] BUF_FULL_SIZE = '1;

  typedef struct {
    logic [2:0]        op;
    logic [WORD_W-1:0] name;
    logic [WORD_W-1:0] depth;
    bit                drain;
  } command_t;

  typedef struct {
    logic              has_word;
    logic [POS_W-1:0]  word_index;
    logic [WORD_W-1:0] word_value;
    logic [1:0]        error_code;
    logic              overflow_flag;
    logic [SP_W-1:0]   stack_depth;
    logic [POS_W-1:0]  hit_count;
    logic              last;
  } record_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SELECT_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [2:0]            operation = OP_INIT;
  logic [WORD_W-1:0]     name_value = '0;
  logic [WORD_W-1:0]     depth_value = '0;
  logic                  out_valid;
  logic                  has_word;
  logic [POS_W-1:0]      word_index;
  logic [WORD_W-1:0]     word_value;
  logic [1:0]            error_code;
  logic                  overflow_flag;
  logic [SP_W-1:0]       stack_depth;
  logic [POS_W-1:0]      hit_count;
  logic                  last;

  selection_name_stack_hit_recorder i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .name_value    (name_value),
    .depth_value   (depth_value),
    .out_valid     (out_valid),
    .has_word      (has_word),
    .word_index    (word_index),
    .word_value    (word_value),
    .error_code    (error_code),
    .overflow_flag (overflow_flag),
    .stack_depth   (stack_depth),
    .hit_count     (hit_count),
    .last          (last)
  );

  always #10 clk = ~clk;

  command_t     cmd_queue[$];
  record_word_t expected_words[$];
  int           sender_idle_pct = 0;
  int           mismatches = 0;
  int           quiet_cycles = 0;
  logic         cmd_accepted = 1'b0;
  int           gen_depth = 0;

  // Predicted state of the recorder.
  logic                  sel_on = 1'b0;
  logic [POS_W-1:0]      buf_words = '0;
  logic [WORD_W-1:0]     names_held [STACK_MAX];
  logic [SP_W-1:0]       names_top = '0;
  logic [WORD_W-1:0]     depth_lo = DEPTH_FAR;
  logic [WORD_W-1:0]     depth_hi = '0;
  logic                  hit_waiting = 1'b0;
  logic [POS_W-1:0]      buf_pos = '0;
  logic                  buf_overrun = 1'b0;
  logic [POS_W-1:0]      records_done = '0;
  logic [POS_W-1:0]      rec_index[$];
  logic [WORD_W-1:0]     rec_value[$];

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    end
  endtask

  task automatic store_word(input logic [WORD_W-1:0] value);
    if (buf_pos >= buf_words) begin
      buf_overrun = 1'b1;
    end else begin
      rec_index.push_back(buf_pos);
      rec_value.push_back(value);
      buf_pos = buf_pos + 1'b1;
    end
  endtask

  task automatic write_hit_record();
    if (buf_words != '0) begin
      store_word(WORD_W'(names_top));
      store_word(depth_lo);
      store_word(depth_hi);
      for (int i = 0; i < names_top; i++) store_word(names_held[i]);
      records_done = records_done + 1'b1;
      depth_lo = DEPTH_FAR;
      depth_hi = '0;
      hit_waiting = 1'b0;
    end
  endtask

  task automatic predict_command(input logic [2:0] op, input logic [WORD_W-1:0] name,
                                 input logic [WORD_W-1:0] depth);
    err_t         err;
    record_word_t rw;
    int           n;
    err = ERR_NONE;
    rec_index.delete();
    rec_value.delete();
    if (sel_on) begin
      case (op)
        OP_INIT: begin
          if (hit_waiting) write_hit_record();
          names_top = '0;
        end
        OP_POP: begin
          if (names_top == 0) begin
            err = ERR_UNDERFLOW;
          end else begin
            if (hit_waiting) write_hit_record();
            names_top = names_top - 1'b1;
          end
        end
        OP_PUSH: begin
          if (names_top >= STACK_MAX) begin
            err = ERR_OVERFLOW;
          end else begin
            if (hit_waiting) write_hit_record();
            names_held[names_top] = name;
            names_top = names_top + 1'b1;
          end
        end
        OP_LOAD: begin
          if (names_top == 0) begin
            err = ERR_INVALID;
          end else begin
            if (hit_waiting) write_hit_record();
            names_held[names_top - 1] = name;
          end
        end
        OP_DEPTH: begin
          if (depth < depth_lo) depth_lo = depth;
          if (depth > depth_hi) depth_hi = depth;
          hit_waiting = 1'b1;
        end
        OP_FLUSH: begin
          if (hit_waiting) write_hit_record();
        end
        default: begin
        end
      endcase
    end
    n = (rec_index.size() == 0) ? 1 : rec_index.size();
    for (int k = 0; k < n; k++) begin
      rw.has_word = (rec_index.size() != 0);
      rw.word_index = rw.has_word ? rec_index[k] : '0;
      rw.word_value = rw.has_word ? rec_value[k] : '0;
      rw.error_code = err;
      rw.overflow_flag = buf_overrun;
      rw.stack_depth = names_top;
      rw.hit_count = records_done;
      rw.last = (k == n - 1);
      expected_words.push_back(rw);
    end
  endtask

  // Monitor: prediction on each accepted command, checking of each result word.
  always @(posedge clk) begin
    record_word_t want;
    if (rst) begin
      cmd_accepted <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      cmd_accepted <= start && !busy;
      if (start && !busy) predict_command(operation, name_value, depth_value);
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word with nothing expected", word_value, '0);
        end else begin
          want = expected_words.pop_front();
          if (has_word !== want.has_word)
            report_mismatch("has_word", WORD_W'(has_word), WORD_W'(want.has_word));
          if (word_index !== want.word_index)
            report_mismatch("word_index", WORD_W'(word_index), WORD_W'(want.word_index));
          if (word_value !== want.word_value)
            report_mismatch("word_value", word_value, want.word_value);
          if (error_code !== want.error_code)
            report_mismatch("error_code", WORD_W'(error_code), WORD_W'(want.error_code));
          if (overflow_flag !== want.overflow_flag)
            report_mismatch("overflow_flag", WORD_W'(overflow_flag),
                            WORD_W'(want.overflow_flag));
          if (stack_depth !== want.stack_depth)
            report_mismatch("stack_depth", WORD_W'(stack_depth), WORD_W'(want.stack_depth));
          if (hit_count !== want.hit_count)
            report_mismatch("hit_count", WORD_W'(hit_count), WORD_W'(want.hit_count));
          if (last !== want.last)
            report_mismatch("last", WORD_W'(last), WORD_W'(want.last));
        end
      end
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Driver: presents queued commands, holding each until it is taken.
  always @(negedge clk) begin
    command_t c;
    if (!rst && (!start || cmd_accepted)) begin
      if (cmd_queue.size() != 0 && (!cmd_queue[0].drain || expected_words.size() == 0) &&
          $urandom_range(99) >= sender_idle_pct) begin
        c = cmd_queue.pop_front();
        start <= 1'b1;
        operation <= c.op;
        name_value <= c.name;
        depth_value <= c.depth;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic add_cmd(input logic [2:0] op, input logic [WORD_W-1:0] name,
                         input logic [WORD_W-1:0] depth, input bit drain = 1'b0);
    command_t c;
    c.op = op;
    c.name = name;
    c.depth = depth;
    c.drain = drain;
    cmd_queue.push_back(c);
    if (sel_on) begin
      case (op)
        OP_INIT: gen_depth = 0;
        OP_POP: if (gen_depth > 0) gen_depth--;
        OP_PUSH: if (gen_depth < STACK_MAX) gen_depth++;
        default: begin
        end
      endcase
    end
  endtask

  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_random(input int count, input int push_pct);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < push_pct) add_cmd(OP_PUSH, pick_value(), pick_value(), i == count / 2);
      else if (r < push_pct + 25) add_cmd(OP_DEPTH, pick_value(), pick_value());
      else if (r < push_pct + 35) add_cmd(OP_LOAD, pick_value(), pick_value());
      else if (r < push_pct + 45) add_cmd(OP_POP, pick_value(), pick_value());
      else if (r < push_pct + 55) add_cmd(OP_FLUSH, pick_value(), pick_value());
      else if (r < push_pct + 58) add_cmd(OP_INIT, pick_value(), pick_value());
      else if (r < push_pct + 60)
        add_cmd(3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), pick_value(), pick_value());
      else add_cmd(OP_DEPTH, pick_value(), pick_value());
    end
  endtask

  // Fills the name stack with hits in between, then pushes past the top.
  task automatic add_climb();
    while (gen_depth < STACK_MAX) begin
      if ($urandom_range(99) < 30) add_cmd(OP_DEPTH, pick_value(), pick_value());
      add_cmd(OP_PUSH, pick_value(), pick_value());
    end
    add_cmd(OP_DEPTH, pick_value(), pick_value());
    add_cmd(OP_PUSH, pick_value(), pick_value());
    add_cmd(OP_PUSH, pick_value(), pick_value());
    add_cmd(OP_LOAD, pick_value(), pick_value());
    add_cmd(OP_DEPTH, pick_value(), pick_value());
    add_cmd(OP_FLUSH, pick_value(), pick_value());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_SELECT_MODE) sel_on = val[0];
    else buf_words = val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (cmd_queue.size() != 0 || start || expected_words.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_reg(CFG_SELECT_MODE, 24'd1);
    write_reg(CFG_BUFFER_SIZE, BUF_FULL_SIZE);
    sender_idle_pct = 0;
    add_cmd(OP_POP, '0, '0);
    add_cmd(OP_LOAD, '1, '1);
    add_cmd(OP_FLUSH, '0, '0);
    add_cmd(OP_DEPTH, '0, '0);
    add_cmd(OP_FLUSH, '0, '0);
    add_cmd(OP_PUSH, '0, '0);
    add_cmd(OP_PUSH, '1, '1);
    add_cmd(OP_DEPTH, '0, '1);
    add_cmd(OP_DEPTH, '0, '0);
    add_cmd(OP_DEPTH, '0, 32'h1234_5678);
    add_cmd(OP_LOAD, 32'hA5A5_A5A5, '0);
    add_cmd(OP_DEPTH, '0, $urandom);
    add_cmd(OP_POP, '0, '0);
    add_cmd(OP_SPARE_LO, '1, '1);
    add_cmd(OP_SPARE_HI, '1, '1);
    add_cmd(OP_DEPTH, '1, $urandom);
    add_cmd(OP_INIT, '0, '0);
    add_cmd(OP_INIT, '0, '0);
    add_cmd(OP_PUSH, $urandom, '0, 1'b1);
    add_cmd(OP_DEPTH, '0, $urandom);
    add_cmd(OP_FLUSH, '0, '0);
    wait_idle();

    sender_idle_pct = 76;
    add_climb();
    add_random(15, 40);
    wait_idle();

    write_reg(CFG_BUFFER_SIZE, buf_pos + POS_W'($urandom_range(60, 20)));
    sender_idle_pct = 37;
    add_random(30, 40);
    wait_idle();

    write_reg(CFG_BUFFER_SIZE, '0);
    sender_idle_pct = 0;
    add_random(12, 40);
    wait_idle();

    write_reg(CFG_BUFFER_SIZE, 24'd1);
    add_random(10, 40);
    wait_idle();

    write_reg(CFG_SELECT_MODE, 24'd0);
    add_random(8, 40);
    wait_idle();

    write_reg(CFG_SELECT_MODE, 24'd1);
    write_reg(CFG_BUFFER_SIZE, BUF_FULL_SIZE);
    sender_idle_pct = 76;
    add_random(25, 35);
    wait_idle();

    repeat (20) @(negedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
